// ----- rtl/dre_pkg.sv -----
package dre_pkg;

    localparam int VALUE_W = 13;
    localparam int SYM_W   = 8;
    localparam int REM_W   = 12;   // remainder never exceeds 3999
    localparam int ENT_W   = 10;   // largest table value is 1000
    localparam int IDX_W   = 4;    // thirteen table entries

    localparam logic [VALUE_W-1:0] MAX_ROMAN = VALUE_W'(3999);

    localparam logic [SYM_W-1:0] SYM_NONE = 8'h00;
    localparam logic [SYM_W-1:0] SYM_I    = 8'h49;
    localparam logic [SYM_W-1:0] SYM_V    = 8'h56;
    localparam logic [SYM_W-1:0] SYM_X    = 8'h58;
    localparam logic [SYM_W-1:0] SYM_L    = 8'h4C;
    localparam logic [SYM_W-1:0] SYM_C    = 8'h43;
    localparam logic [SYM_W-1:0] SYM_D    = 8'h44;
    localparam logic [SYM_W-1:0] SYM_M    = 8'h4D;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_PAIR
    } t_state;

    // One greedy table entry: value, first symbol, optional second symbol.
    typedef struct packed {
        logic [ENT_W-1:0] value;
        logic [SYM_W-1:0] first;
        logic [SYM_W-1:0] second;
        logic             pair;
    } t_entry;

    function automatic t_entry entry_lookup(input logic [IDX_W-1:0] idx);
        t_entry e;
        case (idx)
            4'd0:    e = '{ENT_W'(1000), SYM_M, SYM_NONE, 1'b0};
            4'd1:    e = '{ENT_W'(900),  SYM_C, SYM_M,    1'b1};
            4'd2:    e = '{ENT_W'(500),  SYM_D, SYM_NONE, 1'b0};
            4'd3:    e = '{ENT_W'(400),  SYM_C, SYM_D,    1'b1};
            4'd4:    e = '{ENT_W'(100),  SYM_C, SYM_NONE, 1'b0};
            4'd5:    e = '{ENT_W'(90),   SYM_X, SYM_C,    1'b1};
            4'd6:    e = '{ENT_W'(50),   SYM_L, SYM_NONE, 1'b0};
            4'd7:    e = '{ENT_W'(40),   SYM_X, SYM_L,    1'b1};
            4'd8:    e = '{ENT_W'(10),   SYM_X, SYM_NONE, 1'b0};
            4'd9:    e = '{ENT_W'(9),    SYM_I, SYM_X,    1'b1};
            4'd10:   e = '{ENT_W'(5),    SYM_V, SYM_NONE, 1'b0};
            4'd11:   e = '{ENT_W'(4),    SYM_I, SYM_V,    1'b1};
            default: e = '{ENT_W'(1),    SYM_I, SYM_NONE, 1'b0};
        endcase
        return e;
    endfunction

endpackage

// ----- rtl/decimal_to_roman_encoder_unit.sv -----
// Roman numeral encoder.
// Input channel: i_in_valid / o_in_stall with i_value (13-bit unsigned).
// Output channel: o_out_valid / i_out_stall carrying one ASCII numeral per
// transfer (o_symbol) plus o_last on the final character of the run.
// Zero gives a single transfer with o_empty_res set; values above 3999 give
// a single transfer with o_too_big set; o_symbol is 0 in both cases.
// One subtract/compare unit walks a 13-entry greedy table (M, CM, D, CD, C,
// XC, L, XL, X, IX, V, IV, I). Each cycle that the output is not stalled it
// either emits a character or steps to the next table entry. Zero and
// overflow are loaded into the output register when the item is accepted.
// The block takes one item at a time: o_in_stall stays high until the last
// character is loaded into the output register, and a new item is taken as
// soon as that register is free or being emptied.
// A stall on the output holds the output register and freezes the sequencer.
// Reset (synchronous, active low) returns to idle and drops o_out_valid.
module decimal_to_roman_encoder_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [dre_pkg::VALUE_W-1:0]  i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [dre_pkg::SYM_W-1:0]    o_symbol,
    output logic                         o_last,
    output logic                         o_empty_res,
    output logic                         o_too_big
);
    import dre_pkg::*;

    t_state             r_state, n_state;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [SYM_W-1:0]   r_pair_sym, n_pair_sym;

    logic               r_out_valid;
    logic [SYM_W-1:0]   r_symbol, n_symbol;
    logic               r_last, n_last;
    logic               r_empty, n_empty;
    logic               r_big, n_big;
    logic               out_load;

    t_entry             ent;
    logic [REM_W:0]     diff;
    logic               ge;
    logic               out_free;
    logic               in_xfer;
    logic               in_zero;
    logic               in_big;

    // shared subtract/compare unit
    assign ent  = entry_lookup(r_idx);
    assign diff = {1'b0, r_rem} - {{(REM_W + 1 - ENT_W){1'b0}}, ent.value};
    assign ge   = ~diff[REM_W];

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && out_free);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign in_zero    = (i_value == '0);
    assign in_big     = (i_value > MAX_ROMAN);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && !in_zero && !in_big) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (out_free && ge) begin
                    if (ent.pair) begin
                        n_state = ST_PAIR;
                    end else if (diff[REM_W-1:0] == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_PAIR: begin
                if (out_free) begin
                    n_state = (r_rem == '0) ? ST_IDLE : ST_RUN;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and output register loads
    always_comb begin
        n_rem      = r_rem;
        n_idx      = r_idx;
        n_pair_sym = r_pair_sym;
        out_load   = 1'b0;
        n_symbol   = r_symbol;
        n_last     = r_last;
        n_empty    = r_empty;
        n_big      = r_big;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_rem = i_value[REM_W-1:0];
                    n_idx = '0;
                    if (in_zero || in_big) begin
                        out_load = 1'b1;
                        n_symbol = SYM_NONE;
                        n_last   = 1'b1;
                        n_empty  = in_zero;
                        n_big    = in_big;
                    end
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    if (ge) begin
                        n_rem      = diff[REM_W-1:0];
                        n_pair_sym = ent.second;
                        out_load   = 1'b1;
                        n_symbol   = ent.first;
                        n_last     = !ent.pair && (diff[REM_W-1:0] == '0);
                        n_empty    = 1'b0;
                        n_big      = 1'b0;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            ST_PAIR: begin
                if (out_free) begin
                    // a subtractive pair is used at most once
                    n_idx    = r_idx + IDX_W'(1);
                    out_load = 1'b1;
                    n_symbol = r_pair_sym;
                    n_last   = (r_rem == '0);
                    n_empty  = 1'b0;
                    n_big    = 1'b0;
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_idx      <= n_idx;
        r_pair_sym <= n_pair_sym;
        r_symbol   <= n_symbol;
        r_last     <= n_last;
        r_empty    <= n_empty;
        r_big      <= n_big;
    end

    assign o_out_valid = r_out_valid;
    assign o_symbol    = r_symbol;
    assign o_last      = r_last;
    assign o_empty_res = r_empty;
    assign o_too_big   = r_big;

endmodule

// ----- test/tb.sv -----
module tb;
    import dre_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_LEN   = 6;
    localparam int RANDOM_CNT  = 96;
    localparam int IDLE_PCT    = 11;
    localparam int HOLD_LEN    = 200;
    localparam int DRAIN_LEN   = 40;    // extra wait after the last expected transfer
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_ROWS      = 24;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             empty_res;
        logic             too_big;
    } t_roman_char;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               typed;   // expectation written into the row
        t_roman_char        want;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [VALUE_W-1:0] i_value;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [SYM_W-1:0]   o_symbol;
    logic               o_last;
    logic               o_empty_res;
    logic               o_too_big;

    t_roman_char      expected_chars[$];
    logic [SYM_W-1:0] spelled_chars[$];
    int               err_count;
    int               cycle_count;
    int               in_idle_pct;
    int               out_idle_pct;
    bit               hold_req;
    int               hold_left;

    // directed rows: extremes, each digit form, single-symbol values, errors
    t_stim_row directed_rows[N_ROWS] = '{
        '{13'd0,    1'b1, '{SYM_NONE, 1'b1, 1'b1, 1'b0}},
        '{13'd1,    1'b1, '{SYM_I,    1'b1, 1'b0, 1'b0}},
        '{13'd4000, 1'b1, '{SYM_NONE, 1'b1, 1'b0, 1'b1}},
        '{13'd8191, 1'b1, '{SYM_NONE, 1'b1, 1'b0, 1'b1}},
        '{13'd5,    1'b1, '{SYM_V,    1'b1, 1'b0, 1'b0}},
        '{13'd10,   1'b1, '{SYM_X,    1'b1, 1'b0, 1'b0}},
        '{13'd50,   1'b1, '{SYM_L,    1'b1, 1'b0, 1'b0}},
        '{13'd100,  1'b1, '{SYM_C,    1'b1, 1'b0, 1'b0}},
        '{13'd500,  1'b1, '{SYM_D,    1'b1, 1'b0, 1'b0}},
        '{13'd1000, 1'b1, '{SYM_M,    1'b1, 1'b0, 1'b0}},
        '{13'd3999, 1'b0, '0},
        '{13'd3888, 1'b0, '0},
        '{13'd3,    1'b0, '0},
        '{13'd4,    1'b0, '0},
        '{13'd8,    1'b0, '0},
        '{13'd9,    1'b0, '0},
        '{13'd40,   1'b0, '0},
        '{13'd90,   1'b0, '0},
        '{13'd400,  1'b0, '0},
        '{13'd900,  1'b0, '0},
        '{13'd3000, 1'b0, '0},
        '{13'd1994, 1'b0, '0},
        '{13'd444,  1'b0, '0},
        '{13'd2767, 1'b0, '0}
    };

    decimal_to_roman_encoder_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_symbol    (o_symbol),
        .o_last      (o_last),
        .o_empty_res (o_empty_res),
        .o_too_big   (o_too_big)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // one decimal digit in its hundreds, tens or ones position
    function automatic void spell_digit(input int unsigned d, input logic [SYM_W-1:0] one,
                                        input logic [SYM_W-1:0] five,
                                        input logic [SYM_W-1:0] ten);
        int unsigned k;
        if (d == 9) begin
            spelled_chars.push_back(one);
            spelled_chars.push_back(ten);
        end else if (d >= 5) begin
            spelled_chars.push_back(five);
            for (k = 5; k < d; k++) spelled_chars.push_back(one);
        end else if (d == 4) begin
            spelled_chars.push_back(one);
            spelled_chars.push_back(five);
        end else begin
            for (k = 0; k < d; k++) spelled_chars.push_back(one);
        end
    endfunction

    function automatic void predict_numeral(input logic [VALUE_W-1:0] v);
        int unsigned rest;
        int unsigned k;
        t_roman_char r;
        if (v == '0) begin
            expected_chars.push_back('{SYM_NONE, 1'b1, 1'b1, 1'b0});
            return;
        end
        if (v > MAX_ROMAN) begin
            expected_chars.push_back('{SYM_NONE, 1'b1, 1'b0, 1'b1});
            return;
        end
        spelled_chars.delete();
        rest = v;
        for (k = 0; k < rest / 1000; k++) spelled_chars.push_back(SYM_M);
        rest = rest % 1000;
        spell_digit(rest / 100, SYM_C, SYM_D, SYM_M);
        rest = rest % 100;
        spell_digit(rest / 10, SYM_X, SYM_L, SYM_C);
        spell_digit(rest % 10, SYM_I, SYM_V, SYM_X);
        for (k = 0; k < spelled_chars.size(); k++) begin
            r.symbol    = spelled_chars[k];
            r.last      = (k == spelled_chars.size() - 1);
            r.empty_res = 1'b0;
            r.too_big   = 1'b0;
            expected_chars.push_back(r);
        end
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_value(input logic [VALUE_W-1:0] v, input t_stim_row row);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (row.typed) expected_chars.push_back(row.want);
        else predict_numeral(v);
        @(negedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 5) return '0;
        if (sel < 13) return VALUE_W'($urandom_range(8191, 4000));
        // long runs: thousands digit 1 to 3, other digits drawn from 3, 7, 8
        if (sel < 30) return VALUE_W'($urandom_range(3, 1) * 1000
                                      + ($urandom_range(1) ? 800 : 300)
                                      + ($urandom_range(1) ? 70 : 80)
                                      + ($urandom_range(1) ? 8 : 3));
        return VALUE_W'($urandom_range(3999, 1));
    endfunction

    // receiver: random stall, plus one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        hold_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                i_out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_LEN - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < out_idle_pct);
            end
        end
    end

    // output check, one transfer per rising edge at most
    always @(posedge i_clk) begin
        t_roman_char got;
        t_roman_char want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_symbol, o_last, o_empty_res, o_too_big};
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected transfer sym=%h last=%b empty=%b big=%b",
                         $time, got.symbol, got.last, got.empty_res, got.too_big);
                err_count = err_count + 1;
            end else begin
                want = expected_chars.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected sym=%h last=%b empty=%b big=%b, got sym=%h last=%b empty=%b big=%b",
                             $time, want.symbol, want.last, want.empty_res, want.too_big,
                             got.symbol, got.last, got.empty_res, got.too_big);
                    err_count = err_count + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d transfers still expected", $time, expected_chars.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int n;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_value      = '0;
        err_count    = 0;
        cycle_count  = 0;
        in_idle_pct  = IDLE_PCT;
        out_idle_pct = IDLE_PCT;
        hold_req     = 1'b0;
        repeat (RESET_LEN) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (n = 0; n < N_ROWS; n++)
            send_value(directed_rows[n].value, directed_rows[n]);

        for (n = 0; n < RANDOM_CNT; n++) begin
            // long receiver hold while the sender keeps offering
            if (n == 20) hold_req = 1'b1;
            // stretch with no idling on either side
            if (n == 60) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            if (n == 95) begin
                in_idle_pct  = IDLE_PCT;
                out_idle_pct = IDLE_PCT;
            end
            send_value(pick_value(), '0);
        end
        i_in_valid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_LEN) @(posedge i_clk);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
